@@ rtl/core/signed_int_to_decimal_ascii_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text converter.
// Each macro checks a property on the rising clock edge, with checking held
// off while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent in a cycle implies consequent in the same cycle.
`define SIDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SIDA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/sida_pkg.sv @@
// ---------------------------------------------------------------------------
// sida_pkg
// Shared constants and controller/datapath interface types for the signed
// integer to decimal text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

	// Decimal digits needed for a 32-bit magnitude.
	localparam int unsigned NUM_DIGITS    = 10;
	localparam int unsigned DIGIT_W       = 4;
	localparam int unsigned BCD_W         = NUM_DIGITS * DIGIT_W;
	localparam int unsigned MAG_W         = 32;
	// Binary bits folded into the BCD register per conversion cycle.
	localparam int unsigned BITS_PER_STEP = 4;
	localparam int unsigned CONV_STEPS    = MAG_W / BITS_PER_STEP;
	localparam int unsigned STEP_CNT_W    = $clog2(CONV_STEPS);
	localparam int unsigned IDX_W         = $clog2(NUM_DIGITS);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] sida_bcd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a new value and clear the BCD register
		logic step;       // fold four magnitude bits into the BCD register (shift-and-add-3)
		logic find;       // locate the most significant non-zero digit
		logic dec_idx;    // move on to the next lower digit
		logic sel_minus;  // present the minus sign on the output
	} sida_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;        // the captured value is negative
		logic idx_zero;   // the digit pointer is at the units digit
	} sida_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sida_dp.sv @@
// ---------------------------------------------------------------------------
// sida_dp
// Datapath: magnitude capture, shift-and-add-3 binary to BCD conversion,
// leading digit search and ASCII character formation.
// ---------------------------------------------------------------------------
`default_nettype none

module sida_dp import sida_pkg::*; (
	input  wire logic                    clk,
	input  wire logic signed [MAG_W-1:0] value,
	input  wire sida_cmd_t               cmd,
	output      sida_stat_t              stat,
	output      logic [7:0]              character,
	output      logic                    last
);

	logic [MAG_W-1:0] mag_q;
	sida_bcd_t        bcd_q;
	logic             neg_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] top_idx;
	sida_bcd_t        bcd_next;
	logic [MAG_W-1:0] mag_next;

	// Several dependent shift-and-add-3 steps on the BCD digits.
	function automatic logic [BCD_W+MAG_W-1:0] dabble(input sida_bcd_t bcd,
		input logic [MAG_W-1:0] bin);
		sida_bcd_t        b;
		logic [MAG_W-1:0] m;
		b = bcd;
		m = bin;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d] >= DIGIT_W'(5)) begin
					b[d] = b[d] + DIGIT_W'(3);
				end
			end
			{b, m} = {b, m} << 1;
		end
		return {b, m};
	endfunction

	assign {bcd_next, mag_next} = dabble(bcd_q, mag_q);

	// Highest non-zero digit; the units digit when the value is zero.
	always_comb begin
		top_idx = '0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (bcd_q[d] != '0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	// Working registers; the controller sequences every update.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[MAG_W-1];
			mag_q <= value[MAG_W-1] ? (MAG_W'(0) - MAG_W'($unsigned(value)))
				: MAG_W'($unsigned(value));
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= mag_next;
			bcd_q <= bcd_next;
		end
		if (cmd.find) begin
			idx_q <= top_idx;
		end else if (cmd.dec_idx) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	// Output character: the minus sign or the digit under the pointer.
	assign character = cmd.sel_minus ? ASCII_MINUS
		: (ASCII_ZERO + {{(8 - DIGIT_W){1'b0}}, bcd_q[idx_q]});
	assign last = !cmd.sel_minus && (idx_q == '0);

	assign stat.neg      = neg_q;
	assign stat.idx_zero = (idx_q == '0);

endmodule

`default_nettype wire

@@ rtl/core/sida_ctrl.sv @@
// ---------------------------------------------------------------------------
// sida_ctrl
// Controller: sequences capture, conversion, digit search and the serial
// emission of the sign and digit characters.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_top_macros.svh"

module sida_ctrl import sida_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	output      logic       out_valid,
	input  wire logic       out_stall,
	input  wire sida_stat_t stat,
	output      sida_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_FIND,
		S_SIGN,
		S_DIGIT
	} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] cnt_q;

	// State register and conversion step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (cnt_q == STEP_CNT_W'(CONV_STEPS - 1)) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					state_q <= stat.neg ? S_SIGN : S_DIGIT;
				end
				S_SIGN: begin
					if (!out_stall) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (!out_stall && stat.idx_zero) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Handshake and command decode.
	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = (state_q == S_SIGN) || (state_q == S_DIGIT);
	assign cmd.load      = (state_q == S_IDLE) && in_valid;
	assign cmd.step      = (state_q == S_CONV);
	assign cmd.find      = (state_q == S_FIND);
	assign cmd.dec_idx   = (state_q == S_DIGIT) && !out_stall && !stat.idx_zero;
	assign cmd.sel_minus = (state_q == S_SIGN);

	// A number is never taken while characters are still on offer.
	`SIDA_ASSERT_SAME(a_no_overlap, clk, arst_n, out_valid, in_stall)
	// An accepted value starts a conversion with no output on offer.
	`SIDA_ASSERT_NEXT(a_accept_converts, clk, arst_n, in_valid && !in_stall,
		in_stall && !out_valid)
	// Taking the final digit frees the input side.
	`SIDA_ASSERT_NEXT(a_last_frees, clk, arst_n,
		(state_q == S_DIGIT) && !out_stall && stat.idx_zero, !in_stall)
	// The minus sign is only shown for a negative value.
	`SIDA_ASSERT_SAME(a_sign_neg, clk, arst_n, cmd.sel_minus, stat.neg)

endmodule

`default_nettype wire

@@ rtl/core/signed_int_to_decimal_ascii_top.sv @@
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output beat, with the final character marked by last.
// ---------------------------------------------------------------------------
// Input channel: value with in_valid/in_stall; a beat is taken when in_valid
// is high and in_stall is low. Output channel: character and last with
// out_valid/out_stall; a beat is delivered when out_valid is high and
// out_stall is low.
// A negative value yields a minus sign first; the digits follow most
// significant first with no leading zeros. Zero gives the single character
// "0" and the most negative value gives "-2147483648" in full.
// After the input beat the value passes through the conversion state,
// where the shift-and-add-3 unit folds in four bits per step, and then
// through one leading digit search before the first character is offered.
// Characters then leave one per cycle while out_stall is low.
// Each number gives 1 to 11 characters; the serial conversion unit and
// the single character output bound throughput, as a new number is taken
// only after the final character of the previous one is taken.
// in_stall stays high from the input beat until the final character is
// taken. A stall on the output holds the current character and freezes the
// sequence. Reset returns the block to idle, ready for a new value, and
// drops any text in progress.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_top import sida_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic signed [MAG_W-1:0] value,
	input  wire logic                    in_valid,
	output      logic                    in_stall,
	output      logic [7:0]              character,
	output      logic                    last,
	output      logic                    out_valid,
	input  wire logic                    out_stall
);

	sida_cmd_t  cmd;
	sida_stat_t stat;

	// Sequencing of each number.
	sida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Conversion and character formation.
	sida_dp u_dp (
		.clk       (clk),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire
